/* src/piaw_pkg.sv */
`timescale 1ns / 1ps
package piaw_pkg;

	localparam int TEMP_W  = 18;
	localparam int ERR_W   = 19;
	localparam int INTEG_W = 21;
	localparam int SUM_W   = 22;
	localparam int CTRL_W  = 26;
	localparam int NCLP_W  = 21;
	localparam int DRIVE_W = 17;
	localparam int Y_W     = 30;
	localparam int RECIP_W = 31;
	localparam int SHIFT_K = 44;
	localparam int PROD_W  = Y_W + RECIP_W;
	localparam int QM_W    = DRIVE_W + 14;

	localparam logic signed [SUM_W-1:0]  INTEG_HI = 22'sd1000000;
	localparam logic signed [SUM_W-1:0]  INTEG_LO = -22'sd1000000;
	localparam logic signed [CTRL_W-1:0] FULL_SCALE = 26'sd2000000;
	localparam logic [NCLP_W-1:0]        FULL_SCALE_U = 21'd2000000;

	localparam logic [Y_W-1:0]     ROUND_HALF = 30'd7812;
	localparam logic [RECIP_W-1:0] RECIP_M    = 31'd1125899906;
	localparam logic [13:0]        DIVISOR    = 14'd15625;

	typedef struct packed {
		logic en_s2;
		logic en_s3;
		logic en_out;
	} stage_en_t;

endpackage

/* src/pi_controller_anti_windup_top.sv */
`timescale 1ns / 1ps
// an accepted word passes the input register, the integrator stage register,
// the scale stage register and the output register in that order
// throughput: one word per cycle unless m_tready stalls; a stage refills once empty
// the integrator update is a loop on integ_q within the first stage
// reset: integral, last target and started flag clear; all stages empty
module pi_controller_anti_windup_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // measured_temp[17:0], target_temp[35:18], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // drive_q16[16:0], integral_held[17], zero pad
);

	logic                                      vld_s1_q;
	logic                                      vld_s2_q;
	logic                                      vld_s3_q;
	logic                                      vld_out_q;
	logic signed [piaw_pkg::TEMP_W-1:0]        meas_s1;
	logic signed [piaw_pkg::TEMP_W-1:0]        targ_s1;
	logic        [piaw_pkg::NCLP_W-1:0]        n_s2;
	logic                                      held_s2;
	logic        [piaw_pkg::DRIVE_W-1:0]       drive_q;
	logic                                      held_q;
	logic                                      rdy_out;
	logic                                      rdy_s3;
	logic                                      rdy_s2;
	logic                                      take_in;
	piaw_pkg::stage_en_t                       en;

	always_comb begin
		rdy_out   = !vld_out_q || m_tready;
		en.en_out = vld_s3_q && rdy_out;
		rdy_s3    = !vld_s3_q || rdy_out;
		en.en_s3  = vld_s2_q && rdy_s3;
		rdy_s2    = !vld_s2_q || rdy_s3;
		en.en_s2  = vld_s1_q && rdy_s2;
		s_tready  = !vld_s1_q || rdy_s2;
		take_in   = s_tvalid && s_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1_q  <= 1'b0;
			vld_s2_q  <= 1'b0;
			vld_s3_q  <= 1'b0;
			vld_out_q <= 1'b0;
		end else begin
			if (s_tready) begin
				vld_s1_q <= s_tvalid;
			end
			if (rdy_s2) begin
				vld_s2_q <= vld_s1_q;
			end
			if (rdy_s3) begin
				vld_s3_q <= vld_s2_q;
			end
			if (rdy_out) begin
				vld_out_q <= vld_s3_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			meas_s1 <= s_tdata[17:0];
			targ_s1 <= s_tdata[35:18];
		end
	end

	piaw_integ u_integ (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en.en_s2),
		.meas_s1 (meas_s1),
		.targ_s1 (targ_s1),
		.n_s2    (n_s2),
		.held_s2 (held_s2)
	);

	piaw_scale u_scale (
		.clk     (clk),
		.en      (en),
		.n_s2    (n_s2),
		.held_s2 (held_s2),
		.drive_q (drive_q),
		.held_q  (held_q)
	);

	assign m_tvalid = vld_out_q;
	assign m_tdata  = {6'd0, held_q, drive_q};

endmodule

/* src/piaw_integ.sv */
`timescale 1ns / 1ps
module piaw_integ (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     en,
	input  logic signed [piaw_pkg::TEMP_W-1:0]       meas_s1,
	input  logic signed [piaw_pkg::TEMP_W-1:0]       targ_s1,
	output logic        [piaw_pkg::NCLP_W-1:0]       n_s2,
	output logic                                     held_s2
);

	logic signed [piaw_pkg::INTEG_W-1:0] integ_q;
	logic signed [piaw_pkg::TEMP_W-1:0]  last_target_q;
	logic                                started_q;

	logic                                fresh;
	logic signed [piaw_pkg::ERR_W-1:0]   err;
	logic signed [piaw_pkg::INTEG_W-1:0] prev;
	logic signed [piaw_pkg::SUM_W-1:0]   sum;
	logic signed [piaw_pkg::SUM_W-1:0]   cand;
	logic signed [piaw_pkg::CTRL_W-1:0]  err_x;
	logic signed [piaw_pkg::CTRL_W-1:0]  prop;
	logic signed [piaw_pkg::CTRL_W-1:0]  n_new;
	logic signed [piaw_pkg::CTRL_W-1:0]  n_old;
	logic signed [piaw_pkg::CTRL_W-1:0]  n_sel;
	logic                                held;
	logic        [piaw_pkg::NCLP_W-1:0]  n_clp;

	always_comb begin
		fresh = !started_q || (last_target_q != targ_s1);
		err   = {targ_s1[piaw_pkg::TEMP_W-1], targ_s1} - {meas_s1[piaw_pkg::TEMP_W-1], meas_s1};
		prev  = fresh ? '0 : integ_q;
		sum   = {prev[piaw_pkg::INTEG_W-1], prev}
			+ {{(piaw_pkg::SUM_W-piaw_pkg::ERR_W){err[piaw_pkg::ERR_W-1]}}, err};
		if (sum > piaw_pkg::INTEG_HI) begin
			cand = piaw_pkg::INTEG_HI;
		end else if (sum < piaw_pkg::INTEG_LO) begin
			cand = piaw_pkg::INTEG_LO;
		end else begin
			cand = sum;
		end
		// proportional term, 50 * e
		err_x = {{(piaw_pkg::CTRL_W-piaw_pkg::ERR_W){err[piaw_pkg::ERR_W-1]}}, err};
		prop  = (err_x <<< 5) + (err_x <<< 4) + (err_x <<< 1);
		n_new = prop + {{(piaw_pkg::CTRL_W-piaw_pkg::SUM_W){cand[piaw_pkg::SUM_W-1]}}, cand};
		n_old = prop + {{(piaw_pkg::CTRL_W-piaw_pkg::INTEG_W){prev[piaw_pkg::INTEG_W-1]}}, prev};
		held  = ((n_new > piaw_pkg::FULL_SCALE) && (err > 0))
			|| ((n_new < 0) && (err < 0));
		n_sel = held ? n_old : n_new;
		if (n_sel < 0) begin
			n_clp = '0;
		end else if (n_sel > piaw_pkg::FULL_SCALE) begin
			n_clp = piaw_pkg::FULL_SCALE_U;
		end else begin
			n_clp = n_sel[piaw_pkg::NCLP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q       <= '0;
			last_target_q <= '0;
			started_q     <= 1'b0;
		end else if (en) begin
			integ_q       <= held ? prev : cand[piaw_pkg::INTEG_W-1:0];
			last_target_q <= targ_s1;
			started_q     <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s2    <= n_clp;
			held_s2 <= held;
		end
	end

endmodule

/* src/piaw_scale.sv */
`timescale 1ns / 1ps
module piaw_scale (
	input  logic                               clk,
	input  piaw_pkg::stage_en_t                en,
	input  logic [piaw_pkg::NCLP_W-1:0]        n_s2,
	input  logic                               held_s2,
	output logic [piaw_pkg::DRIVE_W-1:0]       drive_q,
	output logic                               held_q
);

	logic [piaw_pkg::Y_W-1:0]     y;
	logic [piaw_pkg::PROD_W-1:0]  prod;
	logic [piaw_pkg::Y_W-1:0]     y_s3;
	logic [piaw_pkg::DRIVE_W-1:0] q_s3;
	logic                         held_s3;
	logic [piaw_pkg::QM_W-1:0]    qm;
	logic [piaw_pkg::Y_W-1:0]     rem;
	logic [piaw_pkg::DRIVE_W-1:0] q_fix;

	// drive = floor((512n + 7812) / 15625) via reciprocal
	always_comb begin
		y    = {n_s2, 9'd0} + piaw_pkg::ROUND_HALF;
		prod = {{piaw_pkg::RECIP_W{1'b0}}, y} * {{piaw_pkg::Y_W{1'b0}}, piaw_pkg::RECIP_M};
	end

	always_ff @(posedge clk) begin
		if (en.en_s3) begin
			y_s3    <= y;
			q_s3    <= prod[piaw_pkg::SHIFT_K +: piaw_pkg::DRIVE_W];
			held_s3 <= held_s2;
		end
	end

	// estimate is exact or one low
	always_comb begin
		qm    = {{14{1'b0}}, q_s3} * {{piaw_pkg::DRIVE_W{1'b0}}, piaw_pkg::DIVISOR};
		rem   = y_s3 - qm[piaw_pkg::Y_W-1:0];
		q_fix = (rem >= {{(piaw_pkg::Y_W-14){1'b0}}, piaw_pkg::DIVISOR}) ? q_s3 + 1'b1 : q_s3;
	end

	always_ff @(posedge clk) begin
		if (en.en_out) begin
			drive_q <= q_fix;
			held_q  <= held_s3;
		end
	end

endmodule
